[src/pps_pkg.sv]
`default_nettype none

package pps_pkg;

   // input item codes
   localparam logic [2:0] CMD_PALETTE_WRITE = 3'd0;
   localparam logic [2:0] CMD_OPEN_WINDOW   = 3'd1;
   localparam logic [2:0] CMD_PIXEL         = 3'd2;
   localparam logic [2:0] CMD_RAW_COMMAND   = 3'd3;
   localparam logic [2:0] CMD_RAW_DATA      = 3'd4;

   // LCD opcodes
   localparam logic [7:0] OP_CASET = 8'h2A;
   localparam logic [7:0] OP_PASET = 8'h2B;
   localparam logic [7:0] OP_RAMWR = 8'h2C;

   // bus register select
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // palette index is the low six bits of pixel_index
   localparam int unsigned IDX_BITS = 6;

   // window item beat numbers
   localparam int unsigned BEAT_BITS = 4;
   localparam logic [BEAT_BITS-1:0] BEAT_CASET   = 4'd0;
   localparam logic [BEAT_BITS-1:0] BEAT_X_HI    = 4'd1;
   localparam logic [BEAT_BITS-1:0] BEAT_X_LO    = 4'd2;
   localparam logic [BEAT_BITS-1:0] BEAT_XE_HI   = 4'd3;
   localparam logic [BEAT_BITS-1:0] BEAT_XE_LO   = 4'd4;
   localparam logic [BEAT_BITS-1:0] BEAT_PASET   = 4'd5;
   localparam logic [BEAT_BITS-1:0] BEAT_Y_HI    = 4'd6;
   localparam logic [BEAT_BITS-1:0] BEAT_Y_LO    = 4'd7;
   localparam logic [BEAT_BITS-1:0] BEAT_YE_HI   = 4'd8;
   localparam logic [BEAT_BITS-1:0] BEAT_YE_LO   = 4'd9;
   localparam logic [BEAT_BITS-1:0] BEAT_RAMWR   = 4'd10;
   localparam logic [BEAT_BITS-1:0] BEAT_PIX_HI  = 4'd0;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  pixel_index;
      logic [15:0] entry_color;
      logic [15:0] win_x;
      logic [15:0] win_y;
      logic [15:0] win_w;
      logic [15:0] win_h;
      logic [7:0]  byte_value;
   } pps_req_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       reg_select;
      logic       last;
   } pps_rsp_type;

   // palette access, at most one per accepted item
   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [IDX_BITS-1:0] index;
      logic [15:0]         color;
   } pps_pal_req_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } pps_seq_status_type;

endpackage

`default_nettype wire

[src/palette_pixel_streamer_8080.sv]
`default_nettype none

// Indexed-colour pixel streamer for an 8080-style parallel LCD bus. Each item on
// req_ is one of: palette write (stores entry_color at the low six bits of
// pixel_index, no bus bytes), open window (CASET with start/end column, PASET with
// start/end row, then RAMWR: eleven bytes, end = start + size - 1 wrapping at 16
// bits), pixel (palette colour as two data bytes, high first), raw command or raw
// data byte (one byte). Unused cmd codes are swallowed. Each rsp_ item is one bus
// strobe: byte, register select (0 command, 1 data) and a last flag on the final
// byte of its input item. Throughput is one bus byte per cycle while rsp_stall is
// low, set by the single output register. The palette is a synchronous RAM with a
// registered read, read when a pixel is accepted and written when a palette write
// is accepted; items are taken one per edge at most, so a read always sees every
// earlier write. The palette is not cleared at reset: a pixel that looks up an
// entry never written returns an arbitrary colour. Indexes at or above
// PALETTE_ENTRIES are dropped on a write and read back as zero.
module palette_pixel_streamer_8080
   import pps_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire pps_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output pps_rsp_type      rsp_data
);

   logic               accept;
   logic               load;
   pps_pal_req_type    pal_req;
   logic [15:0]        pal_color;
   pps_seq_status_type seq_status;

   // hold the request side only while an item is in work and its last byte is not going out
   assign req_stall = seq_status.busy && !seq_status.finishing;
   assign accept    = req_valid && !req_stall;

   // items that put bytes on the bus go to the sequencer; the rest drop here
   always_comb begin
      unique case (req_data.cmd) inside
         CMD_OPEN_WINDOW, CMD_PIXEL, CMD_RAW_COMMAND, CMD_RAW_DATA: load = accept;
         default:                                                    load = 1'b0;
      endcase
   end

   // one palette access per accepted item: write on a palette write, read on a pixel
   assign pal_req = '{
      wr_en: accept && (req_data.cmd == CMD_PALETTE_WRITE),
      rd_en: accept && (req_data.cmd == CMD_PIXEL),
      index: req_data.pixel_index[IDX_BITS-1:0],
      color: req_data.entry_color
   };

   pps_palette #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .pal_req  (pal_req),
      .pal_color(pal_color)
   );

   pps_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .item     (req_data),
      .pal_color(pal_color),
      .status   (seq_status),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[src/pps_palette.sv]
`default_nettype none

module pps_palette
   import pps_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pps_pal_req_type pal_req,
   output logic [15:0]          pal_color
);

   localparam int unsigned ADDR_BITS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [15:0]          mem [PALETTE_ENTRIES];
   logic [15:0]          rd_data_ff;
   logic                 rd_hit_ff;
   logic [8:0]           idx_wide;
   logic                 in_range;
   logic [ADDR_BITS-1:0] addr;

   assign idx_wide = {{(9 - IDX_BITS){1'b0}}, pal_req.index};
   assign in_range = idx_wide < 9'(PALETTE_ENTRIES);
   // park out-of-range indexes on entry zero; the hit flag masks the read
   assign addr     = in_range ? idx_wide[ADDR_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (pal_req.wr_en && in_range) begin
         mem[addr] <= pal_req.color;
      end
      if (pal_req.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_hit_ff <= 1'b0;
      end else if (pal_req.rd_en) begin
         rd_hit_ff <= in_range;
      end
   end

   assign pal_color = rd_hit_ff ? rd_data_ff : 16'h0000;

endmodule

`default_nettype wire

[src/pps_sequencer.sv]
`default_nettype none

module pps_sequencer
   import pps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire pps_req_type        item,
   input  wire logic [15:0]        pal_color,
   output pps_seq_status_type      status,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output pps_rsp_type             rsp_data
);

   logic                 cur_valid_ff, cur_valid_in;
   logic [2:0]           cur_cmd_ff;
   logic [BEAT_BITS-1:0] cur_beat_ff, cur_beat_in;
   logic [15:0]          cur_x_ff, cur_xe_ff, cur_y_ff, cur_ye_ff;
   logic [7:0]           cur_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pps_rsp_type          rsp_data_ff;
   pps_rsp_type          beat;
   logic                 out_free;
   logic                 fire;
   logic                 finishing;

   // build the byte for the current beat
   always_comb begin
      beat = '{bus_byte: 8'h00, reg_select: RS_DATA, last: 1'b1};
      case (cur_cmd_ff)
         CMD_OPEN_WINDOW: begin
            beat.last = 1'b0;
            unique case (cur_beat_ff)
               BEAT_CASET: beat = '{bus_byte: OP_CASET, reg_select: RS_COMMAND, last: 1'b0};
               BEAT_X_HI:  beat.bus_byte = cur_x_ff[15:8];
               BEAT_X_LO:  beat.bus_byte = cur_x_ff[7:0];
               BEAT_XE_HI: beat.bus_byte = cur_xe_ff[15:8];
               BEAT_XE_LO: beat.bus_byte = cur_xe_ff[7:0];
               BEAT_PASET: beat = '{bus_byte: OP_PASET, reg_select: RS_COMMAND, last: 1'b0};
               BEAT_Y_HI:  beat.bus_byte = cur_y_ff[15:8];
               BEAT_Y_LO:  beat.bus_byte = cur_y_ff[7:0];
               BEAT_YE_HI: beat.bus_byte = cur_ye_ff[15:8];
               BEAT_YE_LO: beat.bus_byte = cur_ye_ff[7:0];
               BEAT_RAMWR: beat = '{bus_byte: OP_RAMWR, reg_select: RS_COMMAND, last: 1'b1};
               default:    beat = '{bus_byte: 8'h00, reg_select: RS_DATA, last: 1'b1};
            endcase
         end
         CMD_PIXEL: begin
            if (cur_beat_ff == BEAT_PIX_HI) begin
               beat = '{bus_byte: pal_color[15:8], reg_select: RS_DATA, last: 1'b0};
            end else begin
               beat = '{bus_byte: pal_color[7:0], reg_select: RS_DATA, last: 1'b1};
            end
         end
         CMD_RAW_COMMAND: beat = '{bus_byte: cur_byte_ff, reg_select: RS_COMMAND, last: 1'b1};
         CMD_RAW_DATA:    beat = '{bus_byte: cur_byte_ff, reg_select: RS_DATA, last: 1'b1};
         default:         beat = '{bus_byte: 8'h00, reg_select: RS_DATA, last: 1'b1};
      endcase
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = cur_valid_ff && out_free;
   assign finishing = fire && beat.last;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_beat_in  = cur_beat_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_beat_in  = '0;
      end else if (finishing) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         cur_beat_in  = cur_beat_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_beat_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_beat_ff  <= cur_beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_cmd_ff  <= item.cmd;
         cur_x_ff    <= item.win_x;
         cur_y_ff    <= item.win_y;
         cur_xe_ff   <= item.win_x + item.win_w - 16'd1;
         cur_ye_ff   <= item.win_y + item.win_h - 16'd1;
         cur_byte_ff <= item.byte_value;
      end
      if (fire) begin
         rsp_data_ff <= beat;
      end
   end

   assign status    = '{busy: cur_valid_ff, finishing: finishing};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!cur_valid_ff || finishing))
      else $error("item loaded over one still in work");

   a_window_beats: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && cur_cmd_ff == CMD_OPEN_WINDOW) |-> (cur_beat_ff <= BEAT_RAMWR))
      else $error("window beat count overran");

   a_retire: assert property (@(posedge clock) disable iff (reset)
      (finishing && !load) |=> !cur_valid_ff)
      else $error("item not retired after its last byte");

endmodule

`default_nettype wire
